@@ rtl/hsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsc_pkg: shared definitions for the Hamming SEC codec
// Word widths, register indexes and the fixed position maps of the code.
// ----------------------------------------------------------------------------
package hsc_pkg;

	localparam int WORD_W        = 63;
	localparam int MAX_INFO_BITS = 57;
	localparam int LEN_W         = 6;
	localparam int SYN_W         = 6;
	localparam int PAR_W         = 3;

	// configuration register indexes
	typedef enum logic [0:0] {
		CFG_INFO_LENGTH = 1'b0,
		CFG_DIRECTION   = 1'b1
	} cfg_index_t;

	// direction codes
	typedef enum logic {
		DIR_ENCODE = 1'b0,
		DIR_DECODE = 1'b1
	} dir_t;

	// 1-based codeword position of data bit d (non-power-of-two slots)
	function automatic logic [SYN_W-1:0] data_pos(input int d);
		int cnt;
		logic [SYN_W-1:0] res;
		cnt = 0;
		res = '0;
		for (int p = 1; p <= WORD_W; p++) begin
			if ((p & (p - 1)) != 0) begin
				if (cnt == d) begin
					res = SYN_W'(p);
				end
				cnt++;
			end
		end
		return res;
	endfunction

	// positions whose 1-based index has bit j set
	function automatic logic [WORD_W-1:0] col_mask(input int j);
		logic [WORD_W-1:0] m;
		m = '0;
		for (int p = 1; p <= WORD_W; p++) begin
			if (((p >> j) & 1) != 0) begin
				m[p-1] = 1'b1;
			end
		end
		return m;
	endfunction

	// smallest r with r + k + 1 <= 2^r
	function automatic logic [PAR_W-1:0] parity_count(input logic [LEN_W-1:0] k);
		logic [PAR_W-1:0] r;
		r = '0;
		for (int i = 0; i < 7; i++) begin
			if ((int'(r) + int'(k) + 1) > (1 << r)) begin
				r = r + PAR_W'(1);
			end
		end
		return r;
	endfunction

endpackage

@@ rtl/hamming_sec_codec.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming_sec_codec: configurable-length Hamming SEC encoder / decoder
// Three-stage pipeline: bit placement, syndrome trees, parity insert or
// correction with data extraction.
// ----------------------------------------------------------------------------
// Usage
//   Configuration: write info_length (index 0) and direction (index 1) over
//   cfg_valid / cfg_ready / cfg_index / cfg_data. cfg_ready is always high.
//   Write only while no request is in flight.
//   Request: in_word is taken at a clock edge with start high and busy low.
//   busy stays low, so a new word may enter every cycle.
//   Result: out_word is shown for one cycle with done high, after the word has
//   passed stage registers s1, s2 and s3; one word per cycle sustained.
//   Stage 1 places bits, stage 2 forms the syndrome with six XOR trees,
//   stage 3 inserts parity or flips the bad bit and gathers the data.
//   Reset clears the pipeline valid bits and sets info_length to 1 and
//   direction to encode. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module hamming_sec_codec (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [hsc_pkg::WORD_W-1:0]       in_word,
	output logic                             done,
	output logic [hsc_pkg::WORD_W-1:0]       out_word,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [0:0]                       cfg_index,
	input  logic [hsc_pkg::LEN_W-1:0]        cfg_data
);

	logic [hsc_pkg::LEN_W-1:0] info_length_q;
	logic                      direction_q;

	logic [hsc_pkg::LEN_W-1:0] k_act;
	logic [hsc_pkg::LEN_W-1:0] n_act;
	logic [hsc_pkg::WORD_W-1:0] k_mask;
	logic [hsc_pkg::WORD_W-1:0] n_mask;

	logic                       accept;
	logic [hsc_pkg::WORD_W-1:0] placed;

	logic                       valid_s1;
	logic                       dir_s1;
	logic [hsc_pkg::WORD_W-1:0] word_s1;

	logic                       valid_s2;
	logic                       dir_s2;
	logic [hsc_pkg::WORD_W-1:0] word_s2;
	logic [hsc_pkg::SYN_W-1:0]  syn_s2;
	logic [hsc_pkg::SYN_W-1:0]  syn;

	logic [hsc_pkg::WORD_W-1:0] enc_word;
	logic [hsc_pkg::WORD_W-1:0] corr_word;
	logic [hsc_pkg::WORD_W-1:0] dec_word;

	logic                       valid_s3;
	logic [hsc_pkg::WORD_W-1:0] word_s3;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			info_length_q <= hsc_pkg::LEN_W'(1);
			direction_q   <= hsc_pkg::DIR_ENCODE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				hsc_pkg::CFG_INFO_LENGTH: info_length_q <= cfg_data;
				hsc_pkg::CFG_DIRECTION:   direction_q   <= cfg_data[0];
				default:                  ;
			endcase
		end
	end

	// active lengths and masks
	always_comb begin
		logic [hsc_pkg::LEN_W:0] n_sum;
		k_act = (info_length_q > hsc_pkg::LEN_W'(hsc_pkg::MAX_INFO_BITS)) ?
			hsc_pkg::LEN_W'(hsc_pkg::MAX_INFO_BITS) : info_length_q;
		n_sum = {1'b0, k_act} + (hsc_pkg::LEN_W + 1)'(hsc_pkg::parity_count(k_act));
		n_act = n_sum[hsc_pkg::LEN_W-1:0];
		k_mask = ~({hsc_pkg::WORD_W{1'b1}} << k_act);
		n_mask = ~({hsc_pkg::WORD_W{1'b1}} << n_act);
	end

	// stage 1 input: scatter data for encode, trim codeword for decode
	always_comb begin
		logic [hsc_pkg::WORD_W-1:0] din;
		din    = in_word & k_mask;
		placed = '0;
		if (direction_q == hsc_pkg::DIR_DECODE) begin
			placed = in_word & n_mask;
		end else begin
			for (int d = 0; d < hsc_pkg::MAX_INFO_BITS; d++) begin
				placed[hsc_pkg::data_pos(d) - 1] = din[d];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= placed;
			dir_s1  <= direction_q;
		end
	end

	// stage 2: syndrome, one xor tree per bit
	always_comb begin
		for (int j = 0; j < hsc_pkg::SYN_W; j++) begin
			syn[j] = ^(word_s1 & hsc_pkg::col_mask(j));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			word_s2 <= word_s1;
			syn_s2  <= syn;
			dir_s2  <= dir_s1;
		end
	end

	// stage 3 encode: drop parity bits into power-of-two slots inside n
	always_comb begin
		enc_word = word_s2;
		for (int j = 0; j < hsc_pkg::SYN_W; j++) begin
			if (n_act >= hsc_pkg::LEN_W'(1 << j)) begin
				enc_word[(1 << j) - 1] = syn_s2[j];
			end
		end
	end

	// stage 3 decode: flip the flagged bit, then gather data bits
	always_comb begin
		corr_word = word_s2;
		if (syn_s2 != '0 && syn_s2 <= n_act) begin
			corr_word = word_s2 ^
				(hsc_pkg::WORD_W'(1) << (syn_s2 - hsc_pkg::SYN_W'(1)));
		end
		dec_word = '0;
		for (int d = 0; d < hsc_pkg::MAX_INFO_BITS; d++) begin
			dec_word[d] = corr_word[hsc_pkg::data_pos(d) - 1];
		end
		dec_word = dec_word & k_mask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			word_s3 <= (dir_s2 == hsc_pkg::DIR_DECODE) ? dec_word : enc_word;
		end
	end

	assign done     = valid_s3;
	assign out_word = word_s3;

`ifndef SYNTHESIS
	// every request comes out as a result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("request did not produce a result");

	// no result without an earlier request
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3))
		else $error("result without request");

	// bits above the active length stay zero
	a_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((out_word & ~((direction_q == hsc_pkg::DIR_DECODE) ?
			k_mask : n_mask)) == '0))
		else $error("output bits above active length set");
`endif

endmodule

@@ tb/tb_hamming_sec_codec.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hamming_sec_codec: self-checking bench for the Hamming SEC codec
// A queue-fed driver pushes data words and register writes into the codec.
// A clocked monitor compares every out_word against a bit-level model of the
// encoder and the correcting decoder. Info lengths run from zero up to beyond
// the largest supported size, in both directions. Sender gaps vary by phase.
// ----------------------------------------------------------------------------
module tb_hamming_sec_codec;

	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 10;
	localparam int CYCLE_LIMIT   = 100000;

	// one entry of the stimulus stream: a data request or a register write
	typedef struct {
		bit                         is_cfg;
		hsc_pkg::cfg_index_t        idx;
		logic [hsc_pkg::LEN_W-1:0]  data;
		logic [hsc_pkg::WORD_W-1:0] word;
		int unsigned                idle_pct;
	} req_t;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       start     = 1'b0;
	logic [hsc_pkg::WORD_W-1:0] in_word   = '0;
	logic                       cfg_valid = 1'b0;
	logic [0:0]                 cfg_index = '0;
	logic [hsc_pkg::LEN_W-1:0]  cfg_data  = '0;
	logic                       busy;
	logic                       done;
	logic [hsc_pkg::WORD_W-1:0] out_word;
	logic                       cfg_ready;

	req_t                       pending_reqs[$];
	logic [hsc_pkg::WORD_W-1:0] expected_words[$];

	// register copies as the codec holds them, and as the generator assumes
	logic [hsc_pkg::LEN_W-1:0]  cur_len = 6'd1;
	hsc_pkg::dir_t              cur_dir = hsc_pkg::DIR_ENCODE;
	logic [hsc_pkg::LEN_W-1:0]  gen_len = 6'd1;
	hsc_pkg::dir_t              gen_dir = hsc_pkg::DIR_ENCODE;

	int                         quiet_cycles = 0;
	int                         cycle_count  = 0;
	int                         mismatches   = 0;

	hamming_sec_codec u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.in_word   (in_word),
		.done      (done),
		.out_word  (out_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [hsc_pkg::WORD_W-1:0] rand_word();
		return {31'($urandom), 32'($urandom)};
	endfunction

	// code length n = k + r, with k clamped to the largest supported size
	function automatic int code_len(input logic [hsc_pkg::LEN_W-1:0] len);
		int k;
		int r;
		k = (len > hsc_pkg::MAX_INFO_BITS) ? hsc_pkg::MAX_INFO_BITS : int'(len);
		r = 0;
		while (r < 7 && r + k + 1 > (1 << r))
			r++;
		return (k + r > hsc_pkg::WORD_W) ? hsc_pkg::WORD_W : k + r;
	endfunction

	// expected out_word for one request under the given register values
	function automatic logic [hsc_pkg::WORD_W-1:0] hamming_expect(
			input logic [hsc_pkg::WORD_W-1:0] w,
			input logic [hsc_pkg::LEN_W-1:0] len, input hsc_pkg::dir_t dir);
		int k;
		int n;
		int d;
		int syn;
		logic [hsc_pkg::WORD_W-1:0] cw;
		logic [hsc_pkg::WORD_W-1:0] res;
		k = (len > hsc_pkg::MAX_INFO_BITS) ? hsc_pkg::MAX_INFO_BITS : int'(len);
		n = code_len(len);
		d = 0;
		syn = 0;
		res = '0;
		if (dir == hsc_pkg::DIR_ENCODE) begin
			// scatter data into non-power-of-two slots, xor of their indexes gives parity
			cw = '0;
			for (int p = 1; p <= n; p++) begin
				if ((p & (p - 1)) != 0) begin
					if (d < k && w[d]) begin
						cw[p-1] = 1'b1;
						syn ^= p;
					end
					d++;
				end
			end
			for (int j = 0; j < 7; j++) begin
				if ((1 << j) <= n && syn[j])
					cw[(1 << j) - 1] = 1'b1;
			end
			res = cw;
		end else begin
			// syndrome over the active positions, flip if it points inside the word
			cw = w;
			for (int p = 1; p <= n; p++) begin
				if (cw[p-1])
					syn ^= p;
			end
			if (syn >= 1 && syn <= n)
				cw[syn-1] = ~cw[syn-1];
			for (int p = 1; p <= n; p++) begin
				if ((p & (p - 1)) != 0) begin
					if (d < k && cw[p-1])
						res[d] = 1'b1;
					d++;
				end
			end
		end
		return res;
	endfunction

	task automatic note_mismatch(input string what);
		$display("ERROR cycle %0d: %s", cycle_count, what);
		mismatches++;
	endtask

	task automatic add_cfg(input hsc_pkg::cfg_index_t idx,
			input logic [hsc_pkg::LEN_W-1:0] data);
		req_t r;
		r.is_cfg   = 1'b1;
		r.idx      = idx;
		r.data     = data;
		r.word     = '0;
		r.idle_pct = 0;
		pending_reqs.push_back(r);
		if (idx == hsc_pkg::CFG_INFO_LENGTH)
			gen_len = data;
		else
			gen_dir = hsc_pkg::dir_t'(data[0]);
	endtask

	// direction write with junk in the unused upper bits
	task automatic add_dir(input hsc_pkg::dir_t dir);
		add_cfg(hsc_pkg::CFG_DIRECTION, {5'($urandom), dir});
	endtask

	task automatic add_req(input logic [hsc_pkg::WORD_W-1:0] w, input int unsigned idle);
		req_t r;
		r.is_cfg   = 1'b0;
		r.idx      = hsc_pkg::CFG_INFO_LENGTH;
		r.data     = '0;
		r.word     = w;
		r.idle_pct = idle;
		pending_reqs.push_back(r);
	endtask

	// driver: retire what was taken at this edge, then present the next entry
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start     <= 1'b0;
			cfg_valid <= 1'b0;
			in_word   <= '0;
			cfg_index <= '0;
			cfg_data  <= '0;
			cur_len      = 6'd1;
			cur_dir      = hsc_pkg::DIR_ENCODE;
			quiet_cycles = 0;
		end else begin : drive
			logic go_req;
			logic go_cfg;
			go_req = 1'b0;
			go_cfg = 1'b0;
			if (start && !busy) begin
				expected_words.push_back(hamming_expect(in_word, cur_len, cur_dir));
				void'(pending_reqs.pop_front());
			end
			if (cfg_valid && cfg_ready) begin
				if (hsc_pkg::cfg_index_t'(cfg_index) == hsc_pkg::CFG_INFO_LENGTH)
					cur_len = cfg_data;
				else
					cur_dir = hsc_pkg::dir_t'(cfg_data[0]);
				void'(pending_reqs.pop_front());
			end
			// register writes only once the pipeline has drained
			if (expected_words.size() == 0 && !start)
				quiet_cycles++;
			else
				quiet_cycles = 0;
			if (pending_reqs.size() != 0) begin
				if (pending_reqs[0].is_cfg)
					go_cfg = (quiet_cycles >= SETTLE_CYCLES);
				else
					go_req = ($urandom_range(99) >= pending_reqs[0].idle_pct);
				cfg_index <= pending_reqs[0].idx;
				cfg_data  <= pending_reqs[0].data;
			end
			in_word   <= go_req ? pending_reqs[0].word : rand_word();
			start     <= go_req;
			cfg_valid <= go_cfg;
		end
	end

	// monitor: each strobed result against the oldest expectation
	always @(posedge clk) begin : check
		logic [hsc_pkg::WORD_W-1:0] want;
		if (arst_n && done) begin
			if (expected_words.size() == 0) begin
				note_mismatch($sformatf("unexpected result out_word=%h", out_word));
			end else begin
				want = expected_words.pop_front();
				if (out_word !== want)
					note_mismatch($sformatf("out_word got %h want %h", out_word, want));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_hamming_sec_codec: FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		logic [hsc_pkg::WORD_W-1:0] cw;
		logic [hsc_pkg::LEN_W-1:0]  len;
		int                         n;
		int                         roll;
		int                         flip;
		int unsigned                idle;

		// reset values: one data bit, encode
		add_req('1, 0);
		add_req(hsc_pkg::WORD_W'(1), 0);

		// encode at the largest size, upper input bits ignored
		add_cfg(hsc_pkg::CFG_INFO_LENGTH, 6'd57);
		add_dir(hsc_pkg::DIR_ENCODE);
		add_req('0, 0);
		add_req('1, 0);
		add_req(hsc_pkg::WORD_W'(1), 0);
		add_req(hsc_pkg::WORD_W'(1) << 56, 0);
		add_req({21{3'b101}}, 0);

		// decode: clean word, errors on parity, last and data positions
		cw = hamming_expect('1, 6'd57, hsc_pkg::DIR_ENCODE);
		add_dir(hsc_pkg::DIR_DECODE);
		add_req(cw, 0);
		add_req(cw ^ hsc_pkg::WORD_W'(1), 0);
		add_req(cw ^ (hsc_pkg::WORD_W'(1) << 62), 0);
		add_req(cw ^ (hsc_pkg::WORD_W'(1) << 2), 0);
		add_req('1, 0);
		add_req('0, 0);

		// short code: syndrome beyond the code length, junk above it
		add_cfg(hsc_pkg::CFG_INFO_LENGTH, 6'd5);
		add_req((hsc_pkg::WORD_W'(1) << 5) | (hsc_pkg::WORD_W'(1) << 8) |
			(hsc_pkg::WORD_W'(1) << 40), 0);
		add_dir(hsc_pkg::DIR_ENCODE);
		add_req('1, 0);

		// info length zero gives an empty code
		add_cfg(hsc_pkg::CFG_INFO_LENGTH, 6'd0);
		add_req('1, 0);
		add_dir(hsc_pkg::DIR_DECODE);
		add_req('1, 0);

		// lengths above the maximum clamp to it
		add_cfg(hsc_pkg::CFG_INFO_LENGTH, 6'd63);
		add_req(hamming_expect('1, 6'd57, hsc_pkg::DIR_ENCODE) ^
			(hsc_pkg::WORD_W'(1) << 10), 0);
		add_dir(hsc_pkg::DIR_ENCODE);
		add_req('1, 0);

		// random phases: every listed length in both directions, then random sizes
		for (int ph = 0; ph < 26; ph++) begin
			case (ph / 2)
				0:       len = 6'd0;
				1:       len = 6'd1;
				2:       len = 6'd2;
				3:       len = 6'd3;
				4:       len = 6'd4;
				5:       len = 6'd5;
				6:       len = 6'd11;
				7:       len = 6'd26;
				8:       len = 6'd56;
				9:       len = 6'd57;
				10:      len = 6'd58;
				11:      len = 6'd63;
				default: len = hsc_pkg::LEN_W'($urandom_range(hsc_pkg::MAX_INFO_BITS, 1));
			endcase
			case (ph % 3)
				0:       idle = 0;
				1:       idle = 49;
				default: idle = 8;
			endcase
			add_cfg(hsc_pkg::CFG_INFO_LENGTH, len);
			add_dir((ph % 2 == 0) ? hsc_pkg::DIR_ENCODE : hsc_pkg::DIR_DECODE);
			n = code_len(gen_len);
			for (int i = 0; i < 40; i++) begin
				roll = $urandom_range(99);
				if (gen_dir == hsc_pkg::DIR_ENCODE) begin
					if (roll < 10)
						cw = '1;
					else if (roll < 20)
						cw = hsc_pkg::WORD_W'(1) << $urandom_range(hsc_pkg::WORD_W - 1);
					else
						cw = rand_word();
				end else begin
					// mostly valid codewords, clean or with one flipped bit
					cw = hamming_expect(rand_word(), gen_len, hsc_pkg::DIR_ENCODE);
					if (roll >= 30 && roll < 80 && n > 0) begin
						flip = $urandom_range(n - 1);
						cw[flip] = ~cw[flip];
					end else if (roll >= 80) begin
						cw = rand_word();
					end
					if ($urandom_range(1) == 1)
						cw |= rand_word() &
							~((hsc_pkg::WORD_W'(1) << n) - hsc_pkg::WORD_W'(1));
				end
				add_req(cw, idle);
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("tb_hamming_sec_codec: PASS");
		end else begin
			$display("tb_hamming_sec_codec: FAIL");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/hsc_pkg.sv
rtl/hamming_sec_codec.sv
tb/tb_hamming_sec_codec.sv
